@@ hdl/rvgw_pkg.sv @@
// rvgw_pkg: shared types, codes and helpers of the rolling voxel grid window
// used by rvgw_map and rolling_voxel_grid_window; no dependencies
`default_nettype none

package rvgw_pkg;

    localparam int DEF_MAX_DIM_X  = 16;
    localparam int DEF_MAX_DIM_Y  = 16;
    localparam int DEF_MAX_DIM_Z  = 16;
    localparam int DEF_WORD_WIDTH = 32;

    localparam int POS_W  = 32;
    localparam int CELL_W = 33;
    localparam int SIZE_W = 5;
    localparam int LIN_W  = 15;
    localparam int SYZ_W  = 10;
    localparam int DEL_W  = 18;

    localparam logic [1:0] MODE_LOCATE   = 2'd0;
    localparam logic [1:0] MODE_WRITE    = 2'd1;
    localparam logic [1:0] MODE_RECENTER = 2'd2;
    localparam logic [1:0] MODE_SPARE    = 2'd3;

    localparam logic [1:0] REG_SIZE_X = 2'd0;
    localparam logic [1:0] REG_SIZE_Y = 2'd1;
    localparam logic [1:0] REG_SIZE_Z = 2'd2;
    localparam logic [1:0] REG_INV    = 2'd3;

    localparam logic [12:0] OUTSIDE_IDX = 13'h1FFF;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [31:0]        cell_word;
    } in_item_t;

    typedef struct packed {
        logic signed [12:0] cell_index;
        logic               inside_res;
        logic [31:0]        read_word;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAP,
        ST_ORIGIN,
        ST_DELTA,
        ST_SHIFT,
        ST_DRAIN,
        ST_LOOK,
        ST_DATA,
        ST_DONE
    } state_t;

    // size register to effective size: zero acts as one, clamp to the maximum
    function automatic logic [SIZE_W-1:0] eff_size(input logic [4:0] s, input int maxd);
        logic [SIZE_W-1:0] r;
        if (s == 5'd0)
            r = SIZE_W'(1);
        else if (int'(s) > maxd)
            r = SIZE_W'(maxd);
        else
            r = s;
        return r;
    endfunction

    // x-major linear index
    function automatic logic [LIN_W-1:0] lin_idx(input logic [SIZE_W-1:0] x,
                                                 input logic [SIZE_W-1:0] y,
                                                 input logic [SIZE_W-1:0] z,
                                                 input logic [SYZ_W-1:0] syz,
                                                 input logic [SIZE_W-1:0] sz);
        logic [LIN_W-1:0] r;
        r = LIN_W'(x) * LIN_W'(syz) + LIN_W'(y) * LIN_W'(sz) + LIN_W'(z);
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hdl/rvgw_map.sv @@
// rvgw_map: maps a Q16.16 position to grid cells, one shared 32x32 multiplier
// depends on rvgw_pkg
`default_nettype none

module rvgw_map
    import rvgw_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic signed [POS_W-1:0]  pos_x,
    input  wire logic signed [POS_W-1:0]  pos_y,
    input  wire logic signed [POS_W-1:0]  pos_z,
    input  wire logic [31:0]              inv,
    output logic                          done,
    output logic signed [CELL_W-1:0]      cell_x,
    output logic signed [CELL_W-1:0]      cell_y,
    output logic signed [CELL_W-1:0]      cell_z
);

    logic [1:0]               cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [63:0]              prod_reg, prod_next;
    logic                     neg_reg, neg_next;
    logic [1:0]               ax_reg, ax_next;
    logic signed [CELL_W-1:0] cx_reg, cy_reg, cz_reg;
    logic signed [CELL_W-1:0] cell_rnd;
    logic [POS_W-1:0]         pos_sel;
    logic [POS_W-1:0]         mag;
    logic [CELL_W-1:0]        cmag;

    always_comb
    begin
        case (cnt_reg)
            2'd0:    pos_sel = pos_x;
            2'd1:    pos_sel = pos_y;
            default: pos_sel = pos_z;
        endcase
        mag       = pos_sel[POS_W-1] ? (~pos_sel + POS_W'(1)) : pos_sel;
        prod_next = 64'(mag) * 64'(inv);
        neg_next  = pos_sel[POS_W-1];
        ax_next   = cnt_reg;
        // round half away from zero
        cmag      = {1'b0, prod_reg[63:32]} + CELL_W'(prod_reg[31]);
        cell_rnd  = neg_reg ? -$signed(cmag) : $signed(cmag);
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                cnt_next  = 2'd0;
            end
        end
        else if (cnt_reg == 2'd3)
        begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
        else
            cnt_next = cnt_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 2'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && cnt_reg != 2'd3)
        begin
            prod_reg <= prod_next;
            neg_reg  <= neg_next;
            ax_reg   <= ax_next;
        end
        if (busy_reg && cnt_reg != 2'd0)
        begin
            case (ax_reg)
                2'd0:    cx_reg <= cell_rnd;
                2'd1:    cy_reg <= cell_rnd;
                default: cz_reg <= cell_rnd;
            endcase
        end
    end

    assign done   = done_reg;
    assign cell_x = cx_reg;
    assign cell_y = cy_reg;
    assign cell_z = cz_reg;

endmodule

`default_nettype wire

@@ hdl/rolling_voxel_grid_window.sv @@
// rolling_voxel_grid_window: top level, cell store, window origin and shift sequencer
// depends on rvgw_pkg and rvgw_map
//
//   channel   | signals                          | direction
//   ----------+----------------------------------+----------
//   in        | in_valid, in_stall, in_data      | item in
//   out       | out_valid, out_stall, out_data   | item out
//   cfg       | cfg_we, cfg_index, cfg_data      | write only
//
// locate and write run from accept through the shared multiplier and its done strobe,
// then origin subtract, linearize and memory read, a data step and the output load;
// recenter adds origin, delta and drain steps around a walk of size_x*size_y*size_z
// cells, one cell a cycle on the store port; after reset the store is cleared, all
// MAX_DIM_X*MAX_DIM_Y*MAX_DIM_Z cells, with no item taken; an item is taken only
// when the block is idle
`default_nettype none

module rolling_voxel_grid_window
    import rvgw_pkg::*;
#(
    parameter int MAX_DIM_X  = DEF_MAX_DIM_X,
    parameter int MAX_DIM_Y  = DEF_MAX_DIM_Y,
    parameter int MAX_DIM_Z  = DEF_MAX_DIM_Z,
    parameter int WORD_WIDTH = DEF_WORD_WIDTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire in_item_t    in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_item_t        out_data,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int DEPTH = MAX_DIM_X * MAX_DIM_Y * MAX_DIM_Z;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WW    = WORD_WIDTH;

    state_t state_reg, state_next;

    logic [4:0]  size_x_reg, size_y_reg, size_z_reg;
    logic [31:0] inv_reg;
    logic [SIZE_W-1:0] sx, sy, sz;
    logic [SYZ_W-1:0]  syz_reg;

    in_item_t item_reg;
    logic [31:0] org_x_reg, org_y_reg, org_z_reg;
    logic [31:0] new_x_reg, new_y_reg, new_z_reg;
    logic [31:0] org_nx, org_ny, org_nz;
    logic [32:0] off_x_reg, off_y_reg, off_z_reg;
    logic [DEL_W-1:0] delta_reg;
    logic [SIZE_W-1:0] a_reg, b_reg, c_reg;
    logic [AW-1:0] clr_reg;

    logic          pend_reg, pend_next;
    logic [AW-1:0] pend_addr_reg;
    logic          pend_ok_reg;

    logic          look_in_reg;
    logic [LIN_W-1:0] look_lin_reg;
    out_item_t     res_reg;
    logic          out_valid_reg, out_valid_next;
    out_item_t     out_reg;

    logic [WW-1:0] mem [DEPTH];
    logic [WW-1:0] mem_q_reg;
    logic          fwd_reg;
    logic [WW-1:0] fwd_data_reg;
    logic [WW-1:0] rd;

    logic          we;
    logic [AW-1:0] wa, ra;
    logic [WW-1:0] wd;
    logic          map_start, map_done;
    logic signed [CELL_W-1:0] cell_x, cell_y, cell_z;

    logic [SIZE_W-1:0] ci, cj, ck;
    logic [LIN_W-1:0]  dst_lin, src_lin, loc_lin;
    logic [DEL_W-1:0]  src_sum;
    logic              src_ok, loc_in, last_cell, load_out;
    logic [33:0]       rel_x, rel_y, rel_z;
    logic [WW-1:0]     wr_word;
    logic [WW+31:0]    wr_wide, rd_wide, nw_wide;
    logic [LIN_W+AW-1:0] dst_wide, src_wide, loc_wide, look_wide;

    function automatic logic in_range(input logic [33:0] t, input logic [SIZE_W-1:0] s);
        return !t[33] && (t < 34'(s));
    endfunction

    function automatic logic [33:0] sh(input logic [SIZE_W-1:0] i, input logic [32:0] o);
        return 34'(i) + {o[32], o};
    endfunction

    rvgw_map u_map (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (map_start),
        .pos_x  (item_reg.pos_x),
        .pos_y  (item_reg.pos_y),
        .pos_z  (item_reg.pos_z),
        .inv    (inv_reg),
        .done   (map_done),
        .cell_x (cell_x),
        .cell_y (cell_y),
        .cell_z (cell_z)
    );

    always_comb
    begin
        sx = eff_size(size_x_reg, MAX_DIM_X);
        sy = eff_size(size_y_reg, MAX_DIM_Y);
        sz = eff_size(size_z_reg, MAX_DIM_Z);

        // new origin centers the window on the cell
        org_nx = cell_x[31:0] - 32'(sx >> 1);
        org_ny = cell_y[31:0] - 32'(sy >> 1);
        org_nz = cell_z[31:0] - 32'(sz >> 1);

        // shift walk: reverse an axis whose offset is negative
        ci = off_x_reg[32] ? (sx - SIZE_W'(1) - a_reg) : a_reg;
        cj = off_y_reg[32] ? (sy - SIZE_W'(1) - b_reg) : b_reg;
        ck = off_z_reg[32] ? (sz - SIZE_W'(1) - c_reg) : c_reg;
        dst_lin = lin_idx(ci, cj, ck, syz_reg, sz);
        src_ok  = in_range(sh(ci, off_x_reg), sx) && in_range(sh(cj, off_y_reg), sy)
                  && in_range(sh(ck, off_z_reg), sz);
        src_sum = DEL_W'(dst_lin) + delta_reg;
        src_lin = src_sum[LIN_W-1:0];
        last_cell = (a_reg == sx - SIZE_W'(1)) && (b_reg == sy - SIZE_W'(1))
                    && (c_reg == sz - SIZE_W'(1));

        rel_x  = {cell_x[CELL_W-1], cell_x} - {{2{org_x_reg[31]}}, org_x_reg};
        rel_y  = {cell_y[CELL_W-1], cell_y} - {{2{org_y_reg[31]}}, org_y_reg};
        rel_z  = {cell_z[CELL_W-1], cell_z} - {{2{org_z_reg[31]}}, org_z_reg};
        loc_in = in_range(rel_x, sx) && in_range(rel_y, sy) && in_range(rel_z, sz);
        loc_lin = lin_idx(rel_x[SIZE_W-1:0], rel_y[SIZE_W-1:0], rel_z[SIZE_W-1:0],
                          syz_reg, sz);

        dst_wide  = {{AW{1'b0}}, dst_lin};
        src_wide  = {{AW{1'b0}}, src_lin};
        loc_wide  = {{AW{1'b0}}, loc_lin};
        look_wide = {{AW{1'b0}}, look_lin_reg};

        rd      = fwd_reg ? fwd_data_reg : mem_q_reg;
        wr_wide = {{WW{1'b0}}, item_reg.cell_word};
        wr_word = wr_wide[WW-1:0];
        rd_wide = {32'd0, rd};
        nw_wide = {32'd0, wr_word};

        load_out = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        pend_next = (state_reg == ST_SHIFT);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (clr_reg == AW'(DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:   if (in_valid) state_next = ST_MAP;
            ST_MAP:
                if (map_done)
                    state_next = (item_reg.mode == MODE_RECENTER) ? ST_ORIGIN : ST_LOOK;
            ST_ORIGIN: state_next = ST_DELTA;
            ST_DELTA:  state_next = ST_SHIFT;
            ST_SHIFT:  if (last_cell) state_next = ST_DRAIN;
            ST_DRAIN:  state_next = ST_LOOK;
            ST_LOOK:   state_next = ST_DATA;
            ST_DATA:   state_next = ST_DONE;
            ST_DONE:   if (load_out) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // state outputs: handshake and store port
    always_comb
    begin
        in_stall  = 1'b1;
        map_start = 1'b0;
        we = 1'b0;
        wa = pend_addr_reg;
        wd = pend_ok_reg ? rd : '0;
        ra = src_wide[AW-1:0];
        unique case (state_reg)
            ST_CLEAR:
            begin
                we = 1'b1;
                wa = clr_reg;
                wd = '0;
            end
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                map_start = in_valid;
            end
            ST_SHIFT, ST_DRAIN:
                we = pend_reg;
            ST_LOOK:
                ra = loc_wide[AW-1:0];
            ST_DATA:
            begin
                we = look_in_reg && (item_reg.mode == MODE_WRITE);
                wa = look_wide[AW-1:0];
                wd = wr_word;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            size_x_reg    <= 5'd16;
            size_y_reg    <= 5'd16;
            size_z_reg    <= 5'd16;
            inv_reg       <= 32'd65536;
            org_x_reg     <= '0;
            org_y_reg     <= '0;
            org_z_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + AW'(1);
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SIZE_X: size_x_reg <= cfg_data[4:0];
                    REG_SIZE_Y: size_y_reg <= cfg_data[4:0];
                    REG_SIZE_Z: size_z_reg <= cfg_data[4:0];
                    REG_INV:    inv_reg    <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == ST_DRAIN)
            begin
                org_x_reg <= new_x_reg;
                org_y_reg <= new_y_reg;
                org_z_reg <= new_z_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        syz_reg <= SYZ_W'(sy) * SYZ_W'(sz);
        if (state_reg == ST_IDLE && in_valid)
            item_reg <= in_data;
        if (state_reg == ST_ORIGIN)
        begin
            new_x_reg <= org_nx;
            new_y_reg <= org_ny;
            new_z_reg <= org_nz;
        end
        if (state_reg == ST_DELTA)
        begin
            delta_reg <= {{(DEL_W-6){off_x_reg[5]}}, off_x_reg[5:0]} * DEL_W'(syz_reg)
                       + {{(DEL_W-6){off_y_reg[5]}}, off_y_reg[5:0]} * DEL_W'(sz)
                       + {{(DEL_W-6){off_z_reg[5]}}, off_z_reg[5:0]};
            a_reg <= '0;
            b_reg <= '0;
            c_reg <= '0;
        end
        if (state_reg == ST_SHIFT)
        begin
            pend_addr_reg <= dst_wide[AW-1:0];
            pend_ok_reg   <= src_ok;
            if (c_reg == sz - SIZE_W'(1))
            begin
                c_reg <= '0;
                if (b_reg == sy - SIZE_W'(1))
                begin
                    b_reg <= '0;
                    a_reg <= a_reg + SIZE_W'(1);
                end
                else
                    b_reg <= b_reg + SIZE_W'(1);
            end
            else
                c_reg <= c_reg + SIZE_W'(1);
        end
        if (state_reg == ST_LOOK)
        begin
            look_in_reg  <= loc_in;
            look_lin_reg <= loc_lin;
        end
        if (state_reg == ST_DATA)
        begin
            res_reg.inside_res <= look_in_reg;
            res_reg.cell_index <= look_in_reg ? look_lin_reg[12:0] : OUTSIDE_IDX;
            if (!look_in_reg)
                res_reg.read_word <= '0;
            else if (item_reg.mode == MODE_WRITE)
                res_reg.read_word <= nw_wide[31:0];
            else
                res_reg.read_word <= rd_wide[31:0];
        end
        if (load_out)
            out_reg <= res_reg;
    end

    // offsets from the old origin, taken in the same cycle as the new origin
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ORIGIN)
        begin
            off_x_reg <= {org_nx[31], org_nx} - {org_x_reg[31], org_x_reg};
            off_y_reg <= {org_ny[31], org_ny} - {org_y_reg[31], org_y_reg};
            off_z_reg <= {org_nz[31], org_nz} - {org_z_reg[31], org_z_reg};
        end
    end

    // cell store, one write and one registered read a cycle, forwarding on a collision
    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        mem_q_reg    <= mem[ra];
        fwd_reg      <= we && (wa == ra);
        fwd_data_reg <= wd;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire
